### design/sbmf_pkg.sv
// Shared constants, register indexes and remainder-unit types for the shifting Bloom filter.
package sbmf_pkg;

	// Default sizing of the filter.
	localparam int MAX_BITS_DEF     = 8192;
	localparam int MAX_HASHES_DEF   = 16;
	localparam int SHIFT_WINDOW_DEF = 57;

	// Fixed field widths.
	localparam int HASH_W    = 64;
	localparam int BITS_W    = 14;
	localparam int HASHES_W  = 5;
	localparam int CFG_W     = 14;
	localparam int CFG_IDX_W = 1;

	// The remainder unit divides a hash word by a divisor of up to 14 bits.
	localparam int DIV_W  = 14;
	localparam int STEP_W = $clog2(HASH_W);

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 1'd1;

	// Request to the remainder unit.
	typedef struct packed {
		logic              start;
		logic [HASH_W-1:0] dividend;
		logic [DIV_W-1:0]  divisor;
	} rem_req_t;

	// Response from the remainder unit.
	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] rem;
	} rem_rsp_t;

endpackage

### design/sbmf_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle across the 64-bit dividend.
module sbmf_rem (
	input  logic               clk,
	input  logic               arst_n,
	input  sbmf_pkg::rem_req_t req,
	output sbmf_pkg::rem_rsp_t rsp
);

	logic                             busy_q;
	logic                             done_q;
	logic [sbmf_pkg::STEP_W-1:0]      cnt_q;
	logic [sbmf_pkg::HASH_W-1:0]      dividend_q;
	logic [sbmf_pkg::DIV_W-1:0]       divisor_q;
	logic [sbmf_pkg::DIV_W-1:0]       rem_q;
	logic [sbmf_pkg::DIV_W:0]         trial;
	logic [sbmf_pkg::DIV_W-1:0]       rem_d;

	// Bring down the next dividend bit and subtract the divisor when it fits.
	always_comb begin
		trial = {rem_q, dividend_q[sbmf_pkg::HASH_W-1]};
		if (trial >= {1'b0, divisor_q}) begin
			rem_d = sbmf_pkg::DIV_W'(trial - {1'b0, divisor_q});
		end else begin
			rem_d = sbmf_pkg::DIV_W'(trial);
		end
	end

	// Control: a start loads the operands, the last step raises done for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {sbmf_pkg::STEP_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dividend_q <= req.dividend;
			divisor_q  <= req.divisor;
			rem_q      <= '0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[sbmf_pkg::HASH_W-2:0], 1'b0};
			rem_q      <= rem_d;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

### design/shifting_bloom_membership_filter.sv
// Top level of the shifting Bloom filter: control sequencer, bit store and result register.
//
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+---------------------------------------
// in      | input     | in_valid / in_stall  | req_type, hash_first, hash_second
// out     | output    | out_valid / out_stall| present (queries only)
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One item at a time: a new item is taken only in ST_IDLE. ST_SHIFT folds the shift out
// of hash_first a byte at a time; each of the k indices then passes through ST_MOD (the
// bit-serial remainder and taking its result), then ST_ACC_P and ST_ACC_O (two single-bit
// accesses in the bit store) and ST_STEP; a query then passes through ST_EMIT.
// After reset the bit store is swept to zero, one bit per cycle, over all
// MAX_BITS + SHIFT_WINDOW - 1 bits (8248 at default sizing); no item is taken then.
// A finished query waits in the output register while out_stall is high.
module shifting_bloom_membership_filter #(
	parameter int MAX_BITS     = sbmf_pkg::MAX_BITS_DEF,
	parameter int MAX_HASHES   = sbmf_pkg::MAX_HASHES_DEF,
	parameter int SHIFT_WINDOW = sbmf_pkg::SHIFT_WINDOW_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sbmf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbmf_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           req_type,
	input  logic [sbmf_pkg::HASH_W-1:0]    hash_first,
	input  logic [sbmf_pkg::HASH_W-1:0]    hash_second,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           present
);

	localparam int DEPTH  = MAX_BITS + SHIFT_WINDOW - 1;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SH_W   = $clog2(SHIFT_WINDOW);

	// Shift remainder by the constant SHIFT_WINDOW - 1, one byte of hash_first per cycle.
	// The reciprocal is rounded up; with a divisor below 256 the quotient is exact.
	localparam int SH_DIV     = SHIFT_WINDOW - 1;
	localparam int SH_DIGIT_W = 8;
	localparam int SH_ACC_W   = SH_W + SH_DIGIT_W;
	localparam int RECIP_W    = 24;
	localparam int SH_PROD_W  = SH_ACC_W + RECIP_W;
	localparam int SH_STEPS   = sbmf_pkg::HASH_W / SH_DIGIT_W;
	localparam int SH_CNT_W   = $clog2(SH_STEPS);
	localparam logic [RECIP_W-1:0] SH_RECIP = RECIP_W'((2**RECIP_W + SH_DIV - 1) / SH_DIV);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_SHIFT = 8'b0000_0100,
		ST_MOD   = 8'b0000_1000,
		ST_ACC_P = 8'b0001_0000,
		ST_ACC_O = 8'b0010_0000,
		ST_STEP  = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	state_t                          state_q;
	state_t                          state_d;
	logic [sbmf_pkg::BITS_W-1:0]     bit_count_q;
	logic [sbmf_pkg::HASHES_W-1:0]   hash_count_q;
	logic [sbmf_pkg::BITS_W-1:0]     m_eff;
	logic [sbmf_pkg::HASHES_W-1:0]   k_eff;
	logic                            query_q;
	logic [sbmf_pkg::HASH_W-1:0]     h2_q;
	logic [sbmf_pkg::HASH_W-1:0]     x_q;
	logic [sbmf_pkg::HASH_W-1:0]     x_next;
	logic [SH_W-1:0]                 shift_q;
	logic [ADDR_W-1:0]               p_q;
	logic [ADDR_W-1:0]               po_addr;
	logic [sbmf_pkg::HASHES_W-1:0]   idx_q;
	logic                            all_set_q;
	logic [ADDR_W-1:0]               clr_addr_q;
	logic                            in_accept;
	logic                            can_emit;
	logic                            last_idx;
	sbmf_pkg::rem_req_t              rem_req;
	sbmf_pkg::rem_rsp_t              rem_rsp;

	// Shift remainder signals.
	logic [sbmf_pkg::HASH_W-1:0]     sh_word_q;
	logic [SH_W-1:0]                 sh_rem_q;
	logic [SH_CNT_W-1:0]             sh_cnt_q;
	logic                            sh_last;
	logic [SH_ACC_W-1:0]             sh_acc;
	logic [SH_PROD_W-1:0]            sh_prod;
	logic [SH_ACC_W-1:0]             sh_quo;
	logic [SH_W-1:0]                 sh_rem_d;

	// Bit store and its port signals.
	logic                            filter_q [DEPTH];
	logic                            rd_data_q;
	logic                            mem_we;
	logic [ADDR_W-1:0]               mem_waddr;
	logic                            mem_wdata;
	logic [ADDR_W-1:0]               mem_raddr;
	logic                            out_valid_q;
	logic                            present_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign can_emit  = !out_valid_q || !out_stall;
	assign x_next    = x_q + h2_q;
	assign po_addr   = p_q + ADDR_W'(shift_q);
	assign last_idx  = (idx_q == k_eff);
	assign sh_last   = (sh_cnt_q == SH_CNT_W'(SH_STEPS - 1));

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q  <= sbmf_pkg::BITS_W'(8192);
			hash_count_q <= sbmf_pkg::HASHES_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbmf_pkg::REG_BIT_COUNT: begin
					bit_count_q <= cfg_data[sbmf_pkg::BITS_W-1:0];
				end
				sbmf_pkg::REG_HASH_COUNT: begin
					hash_count_q <= cfg_data[sbmf_pkg::HASHES_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Effective modulus and hash count, with zero taken as one and saturation at the maximum.
	always_comb begin
		if (bit_count_q == '0) begin
			m_eff = sbmf_pkg::BITS_W'(1);
		end else if (32'(bit_count_q) > MAX_BITS) begin
			m_eff = sbmf_pkg::BITS_W'(MAX_BITS);
		end else begin
			m_eff = bit_count_q;
		end
		if (hash_count_q == '0) begin
			k_eff = sbmf_pkg::HASHES_W'(1);
		end else if (32'(hash_count_q) > MAX_HASHES) begin
			k_eff = sbmf_pkg::HASHES_W'(MAX_HASHES);
		end else begin
			k_eff = hash_count_q;
		end
	end

	// One step of the shift remainder: bring in the next byte and reduce by reciprocal.
	always_comb begin
		sh_acc   = {sh_rem_q, sh_word_q[sbmf_pkg::HASH_W-1 -: SH_DIGIT_W]};
		sh_prod  = SH_PROD_W'(sh_acc) * SH_PROD_W'(SH_RECIP);
		sh_quo   = sh_prod[SH_PROD_W-1 -: SH_ACC_W];
		sh_rem_d = SH_W'(sh_acc - sh_quo * SH_ACC_W'(SH_DIV));
	end

	// Remainder requests: the first index once the shift is done, then one per further index.
	always_comb begin
		rem_req.start    = 1'b0;
		rem_req.dividend = x_next;
		rem_req.divisor  = m_eff;
		if (state_q == ST_SHIFT) begin
			rem_req.start    = sh_last;
			rem_req.dividend = x_q;
		end else if (state_q == ST_STEP) begin
			rem_req.start    = !last_idx;
			rem_req.dividend = x_next;
		end
	end

	sbmf_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_accept) state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (sh_last) state_d = ST_MOD;
			end
			ST_MOD: begin
				if (rem_rsp.done) state_d = ST_ACC_P;
			end
			ST_ACC_P: begin
				state_d = ST_ACC_O;
			end
			ST_ACC_O: begin
				state_d = ST_STEP;
			end
			ST_STEP: begin
				if (!last_idx) begin
					state_d = ST_MOD;
				end else if (query_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (can_emit) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers of the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Per-item working registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			query_q   <= req_type;
			h2_q      <= hash_second;
			x_q       <= hash_first + hash_second;
			idx_q     <= sbmf_pkg::HASHES_W'(1);
			all_set_q <= 1'b1;
			sh_word_q <= hash_first;
			sh_rem_q  <= '0;
			sh_cnt_q  <= '0;
		end
		if (state_q == ST_SHIFT) begin
			sh_word_q <= {sh_word_q[sbmf_pkg::HASH_W-SH_DIGIT_W-1:0], SH_DIGIT_W'(0)};
			sh_rem_q  <= sh_rem_d;
			sh_cnt_q  <= sh_cnt_q + 1'b1;
			if (sh_last) shift_q <= sh_rem_d + SH_W'(1);
		end
		if (state_q == ST_MOD && rem_rsp.done) begin
			p_q <= ADDR_W'(rem_rsp.rem);
		end
		// Fold in the registered read data: bit p in ACC_O, bit p+o in STEP.
		if (state_q == ST_ACC_O || state_q == ST_STEP) begin
			all_set_q <= all_set_q & rd_data_q;
		end
		if (state_q == ST_STEP && !last_idx) begin
			x_q   <= x_next;
			idx_q <= idx_q + 1'b1;
		end
	end

	// Bit store port: clearing sweep or insert writes; query reads.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = p_q;
		mem_wdata = 1'b1;
		mem_raddr = p_q;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = 1'b0;
		end else if (state_q == ST_ACC_P) begin
			mem_we = !query_q;
		end else if (state_q == ST_ACC_O) begin
			mem_we    = !query_q;
			mem_waddr = po_addr;
			mem_raddr = po_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) filter_q[mem_waddr] <= mem_wdata;
		rd_data_q <= filter_q[mem_raddr];
	end

	// Output register for query answers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (state_q == ST_EMIT && can_emit) out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && can_emit) present_q <= all_set_q;
	end

	assign out_valid = out_valid_q;
	assign present   = present_q;

endmodule

### sim/tb_shifting_bloom_membership_filter.sv
// Self-checking testbench for the shifting Bloom filter: directed table, then random phases.
module tb_shifting_bloom_membership_filter;

	// Request codes on req_type.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam int STORE_DEPTH = sbmf_pkg::MAX_BITS_DEF + sbmf_pkg::SHIFT_WINDOW_DEF - 1;

	// Tail wait sized from the slowest item; the limit allows long stalls and the clearing sweep.
	localparam int TAIL_CYCLES = 10 + 68 * sbmf_pkg::MAX_HASHES_DEF + 64;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int MAX_REPORTS = 50;

	// One row of the directed table; answer is only used where fixed is set.
	typedef struct packed {
		logic                        op;
		logic [sbmf_pkg::HASH_W-1:0] first;
		logic [sbmf_pkg::HASH_W-1:0] second;
		logic                        fixed;
		logic                        answer;
	} probe_t;

	// One random phase: register values, length and idling pattern.
	typedef struct packed {
		logic [sbmf_pkg::CFG_W-1:0] bits_data;
		logic [sbmf_pkg::CFG_W-1:0] hashes_data;
		int                         items;
		int                         send_idle;
		int                         recv_stall;
		int                         hold_cycles;
	} phase_t;

	typedef struct packed {
		logic [sbmf_pkg::HASH_W-1:0] first;
		logic [sbmf_pkg::HASH_W-1:0] second;
	} element_t;

	localparam int NUM_PROBES = 21;
	localparam probe_t PROBES [NUM_PROBES] = '{
		// Empty filter after reset.
		'{OP_QUERY,  64'h0, 64'h0, 1'b1, 1'b0},
		'{OP_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0},
		// An inserted element is always found again.
		'{OP_INSERT, 64'h0, 64'h0, 1'b0, 1'b0},
		'{OP_QUERY,  64'h0, 64'h0, 1'b1, 1'b1},
		'{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
		'{OP_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1},
		// Base index 8191 with the widest shift reaches the last stored bit.
		'{OP_INSERT, 64'd57343, 64'h0, 1'b0, 1'b0},
		'{OP_QUERY,  64'd57343, 64'h0, 1'b1, 1'b1},
		// Widest and narrowest shift.
		'{OP_INSERT, 64'd55, 64'h0, 1'b0, 1'b0},
		'{OP_QUERY,  64'd55, 64'h0, 1'b1, 1'b1},
		'{OP_INSERT, 64'd56, 64'd1, 1'b0, 1'b0},
		'{OP_QUERY,  64'd56, 64'd1, 1'b1, 1'b1},
		// The index sum wraps around 2^64.
		'{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 1'b0, 1'b0},
		'{OP_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 1'b1, 1'b1},
		// Near misses and alternating bit patterns.
		'{OP_QUERY,  64'd8191, 64'h0, 1'b0, 1'b0},
		'{OP_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 1'b0},
		'{OP_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0},
		'{OP_QUERY,  64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1},
		'{OP_QUERY,  64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0, 1'b0},
		'{OP_QUERY,  64'd516095, 64'h0, 1'b0, 1'b0},
		'{OP_QUERY,  64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0}
	};

	// Zero and oversized counts, upper write-data bits on hash_count, all idling patterns.
	localparam int NUM_PHASES = 9;
	localparam phase_t PHASES [NUM_PHASES] = '{
		'{14'd0,     14'h3FE0, 80,  0,  0,  0},
		'{14'd64,    14'h1543, 80,  82, 0,  0},
		'{14'd16383, 14'd31,   20,  0,  82, 0},
		'{14'd1000,  14'd2,    80,  0,  0,  4000},
		'{14'd8192,  14'd4,    80,  31, 31, 0},
		'{14'd37,    14'd16,   20,  82, 0,  0},
		'{14'd8193,  14'd1,    100, 0,  82, 0},
		'{14'd5000,  14'h2005, 60,  31, 31, 0},
		'{14'd1,     14'd17,   10,  0,  0,  0}
	};

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we = 1'b0;
	logic [sbmf_pkg::CFG_IDX_W-1:0] cfg_index = sbmf_pkg::REG_BIT_COUNT;
	logic [sbmf_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic                           req_type = OP_INSERT;
	logic [sbmf_pkg::HASH_W-1:0]    hash_first = '0;
	logic [sbmf_pkg::HASH_W-1:0]    hash_second = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic                           present;

	// Shadow of the filter and its registers.
	bit                              filter_copy [STORE_DEPTH];
	logic [sbmf_pkg::BITS_W-1:0]     bit_count_reg = 14'd8192;
	logic [sbmf_pkg::HASHES_W-1:0]   hash_count_reg = 5'd1;

	logic     pending_answers [$];
	element_t stored_elements [$];
	logic     expected_answer;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_len = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int mismatch_count = 0;
	int requests_sent = 0;
	int answers_checked = 0;
	int p;
	int n;

	shifting_bloom_membership_filter u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.hash_first  (hash_first),
		.hash_second (hash_second),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.present     (present)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Effective register values after clamping.
	function automatic logic [sbmf_pkg::HASH_W-1:0] bits_in_use();
		if (bit_count_reg == 0) return 64'd1;
		if (bit_count_reg > sbmf_pkg::MAX_BITS_DEF) return 64'(sbmf_pkg::MAX_BITS_DEF);
		return 64'(bit_count_reg);
	endfunction

	function automatic int hashes_in_use();
		if (hash_count_reg == 0) return 1;
		if (hash_count_reg > sbmf_pkg::MAX_HASHES_DEF) return sbmf_pkg::MAX_HASHES_DEF;
		return int'(hash_count_reg);
	endfunction

	// Sets the element's bits on insert; on query returns whether all of them are set.
	function automatic logic apply_request(input logic op,
			input logic [sbmf_pkg::HASH_W-1:0] h1, input logic [sbmf_pkg::HASH_W-1:0] h2);
		logic [sbmf_pkg::HASH_W-1:0] modulus;
		logic [sbmf_pkg::HASH_W-1:0] shift;
		logic [sbmf_pkg::HASH_W-1:0] pos;
		logic [sbmf_pkg::HASH_W-1:0] step;
		logic                        all_set;
		modulus = bits_in_use();
		shift = h1 % 64'(sbmf_pkg::SHIFT_WINDOW_DEF - 1) + 64'd1;
		all_set = 1'b1;
		for (step = 64'd1; step <= 64'(hashes_in_use()); step++) begin
			pos = (h1 + step * h2) % modulus;
			if (op == OP_QUERY) begin
				if (!filter_copy[pos] || !filter_copy[pos + shift]) all_set = 1'b0;
			end else begin
				filter_copy[pos] = 1'b1;
				filter_copy[pos + shift] = 1'b1;
			end
		end
		return all_set;
	endfunction

	function automatic logic [sbmf_pkg::HASH_W-1:0] rand_word();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Offers one transaction, waits for its acceptance and records the expected answer.
	task automatic send_item(input logic op, input logic [sbmf_pkg::HASH_W-1:0] h1,
			input logic [sbmf_pkg::HASH_W-1:0] h2, input logic fixed,
			input logic fixed_answer);
		int unsigned gap;
		logic        answer;
		gap = 0;
		if (send_idle_pct != 0) begin
			if ($urandom_range(3) == 0) gap = $urandom_range(16 * send_idle_pct);
			else while ($urandom_range(99) < send_idle_pct) gap++;
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		hash_first <= h1;
		hash_second <= h2;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		answer = apply_request(op, h1, h2);
		if (op == OP_QUERY) pending_answers.push_back(fixed ? fixed_answer : answer);
		requests_sent++;
	endtask

	// Drops valid and waits until every outstanding query has been answered.
	task automatic await_answers();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0) @(posedge clk);
	endtask

	task automatic write_registers(input logic [sbmf_pkg::CFG_W-1:0] bits_data,
			input logic [sbmf_pkg::CFG_W-1:0] hashes_data);
		cfg_we <= 1'b1;
		cfg_index <= sbmf_pkg::REG_BIT_COUNT;
		cfg_data <= bits_data;
		@(posedge clk);
		cfg_index <= sbmf_pkg::REG_HASH_COUNT;
		cfg_data <= hashes_data;
		@(posedge clk);
		cfg_we <= 1'b0;
		bit_count_reg = bits_data[sbmf_pkg::BITS_W-1:0];
		hash_count_reg = hashes_data[sbmf_pkg::HASHES_W-1:0];
	endtask

	// Mostly insert-then-query of remembered elements, plus fresh and near-miss queries.
	task automatic random_request();
		element_t    e;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40 || stored_elements.size() == 0) begin
			e = '{rand_word(), rand_word()};
			stored_elements.push_back(e);
			if (stored_elements.size() > 64) stored_elements.delete(0);
			send_item(OP_INSERT, e.first, e.second, 1'b0, 1'b0);
		end else if (pick < 75) begin
			e = stored_elements[$urandom_range(stored_elements.size() - 1)];
			send_item(OP_QUERY, e.first, e.second, 1'b0, 1'b0);
		end else if (pick < 90) begin
			send_item(OP_QUERY, rand_word(), rand_word(), 1'b0, 1'b0);
		end else begin
			e = stored_elements[$urandom_range(stored_elements.size() - 1)];
			if ($urandom_range(1)) e.first[$urandom_range(sbmf_pkg::HASH_W - 1)] ^= 1'b1;
			else e.second[$urandom_range(sbmf_pkg::HASH_W - 1)] ^= 1'b1;
			send_item(OP_QUERY, e.first, e.second, 1'b0, 1'b0);
		end
	endtask

	// Output side: random stalls, long hold-offs on request, and answer checking.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = hold_len;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end

		if (out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: answer with none expected: expected nothing, got present=%0b",
						$time, present);
			end else begin
				expected_answer = pending_answers.pop_front();
				answers_checked++;
				if (present !== expected_answer) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: present mismatch: expected %0b, got %0b",
							$time, expected_answer, present);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d answers outstanding",
				$time, cycle_count, pending_answers.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table under the reset settings; the block sweeps its store first.
		for (n = 0; n < NUM_PROBES; n++)
			send_item(PROBES[n].op, PROBES[n].first, PROBES[n].second,
				PROBES[n].fixed, PROBES[n].answer);

		// Random phases, each started from an idle block.
		for (p = 0; p < NUM_PHASES; p++) begin
			await_answers();
			repeat (10 + 68 * hashes_in_use() + 16) @(posedge clk);
			write_registers(PHASES[p].bits_data, PHASES[p].hashes_data);
			send_idle_pct = PHASES[p].send_idle;
			recv_stall_pct = PHASES[p].recv_stall;
			if (PHASES[p].hold_cycles != 0) begin
				hold_len = PHASES[p].hold_cycles;
				hold_requests++;
			end
			for (n = 0; n < PHASES[p].items; n++) begin
				// Halfway through, the sender waits for the output side to catch up.
				if (n == PHASES[p].items / 2) await_answers();
				random_request();
			end
		end

		await_answers();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d requests and %0d checked answers over %0d register settings.",
			requests_sent, answers_checked, NUM_PHASES + 1);
		$display("Counts were written at zero, in range and oversized, under idle and stalled sides.");
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
